@@ hdl/sfrm_pkg.sv @@
package sfrm_pkg;

  // Register selects on the bus.
  localparam logic [2:0] SEL_MODE = 3'd0;
  localparam logic [2:0] SEL_ADDR = 3'd1;
  localparam logic [2:0] SEL_CMD  = 3'd2;
  localparam logic [2:0] SEL_PAGE = 3'd3;

  // Transaction status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;

  // Command register codes.
  localparam logic [31:0] CMD_FLAG_STATUS = 32'h0070_0001;
  localparam logic [31:0] CMD_FLAG_DONE   = 32'h0070_0080;
  localparam logic [31:0] CMD_ERASE_3B    = 32'h80D8_0003;
  localparam logic [31:0] CMD_ERASE_4B    = 32'h80D8_0004;
  localparam logic [31:0] CMD_PROG_3B     = 32'h8002_0103;
  localparam logic [31:0] CMD_PROG_4B     = 32'h8012_0104;
  localparam logic [31:0] CMD_READ_3B     = 32'h0003_0103;
  localparam logic [31:0] CMD_READ_4B     = 32'h0013_0104;
  localparam logic [31:0] CMD_WREN        = 32'h8006_0000;
  localparam logic [31:0] CMD_WRDI        = 32'h8004_0000;

  localparam logic [31:0] ADDR_MASK_NARROW = 32'h00FF_FFFF;

  // Kind of work a decoded transaction needs after the decode cycle.
  typedef enum logic [2:0] {
    RUN_NONE,
    RUN_PBUF,
    RUN_ERASE,
    RUN_PROG,
    RUN_READ
  } run_t;

  // Flash write data source.
  typedef enum logic [1:0] {
    FW_NONE,
    FW_ZERO,
    FW_ONES,
    FW_AND
  } fw_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic decode;
    logic start;
    logic step;
    fw_t  fl_wsel;
    logic fl_rd;
    logic pb_rd_bus;
    logic pb_rd_op;
    logic pb_wr_op;
    logic take_pbuf;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    run_t run;
    logic addr_end;
    logic sector_end;
    logic page_end;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/sfrm_dp.sv @@
module sfrm_dp
  import sfrm_pkg::*;
#(
  parameter int FLASH_BYTES  = 1048576,
  parameter int PAGE_WORDS   = 64,
  parameter int SECTOR_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        in_req_type,
  input  logic [2:0]  in_reg_select,
  input  logic [5:0]  in_word_index,
  input  logic [31:0] in_write_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_status
);

  localparam int AW         = $clog2(FLASH_BYTES);
  localparam int PWW        = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
  localparam int PAGE_BYTES = PAGE_WORDS * 4;
  localparam int CW         = $clog2(SECTOR_BYTES);

  typedef enum logic [2:0] {
    OP_FLAG,
    OP_ERASE,
    OP_PROG,
    OP_READ,
    OP_WREN,
    OP_WRDI,
    OP_BAD
  } op_t;

  // Latched request.
  logic        req_wr_r;
  logic [2:0]  req_sel_r;
  logic [5:0]  req_widx_r;
  logic [31:0] req_data_r;

  // Architectural registers.
  logic [31:0] mode_r;
  logic [31:0] addr_r;
  logic [31:0] cmd_r;
  logic        wen_r;

  // Sequencer position.
  logic [AW-1:0] cur_r;
  logic [CW-1:0] cnt_r;

  // Result and output registers.
  logic [31:0] res_data_r;
  logic [1:0]  res_status_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [1:0]  out_status_r;

  // Memories.
  logic [7:0]            flash_mem [FLASH_BYTES];
  logic [7:0]            fl_q_r;
  logic [31:0]           pb_mem [PAGE_WORDS];
  logic [31:0]           pb_q_r;
  logic [PAGE_BYTES-1:0] pb_vld_r;
  logic [3:0]            pb_vq_r;

  // Decode signals.
  logic [8:0]  widx_ext;
  logic        is_unm;
  logic        is_pb;
  logic        pb_in;
  logic        is_scalar;
  logic        wide;
  logic        var_ok;
  logic        span_ok;
  logic        cmd_go;
  op_t         op;
  run_t        run;
  logic [1:0]  dec_status;
  logic [31:0] dec_rdata;

  // Memory port signals.
  logic [PWW-1:0] bus_word;
  logic [PWW-1:0] op_word;
  logic [PWW-1:0] pb_ra;
  logic [PWW-1:0] pb_wa;
  logic           pb_rd;
  logic           pb_bus_wr;
  logic [3:0]     pb_be;
  logic [31:0]    pb_wd;
  logic [31:0]    pb_rdata;
  logic [7:0]     pb_byte;
  logic           fl_we;
  logic [7:0]     fl_wd;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_wr_r   <= in_req_type;
      req_sel_r  <= in_reg_select;
      req_widx_r <= in_word_index;
      req_data_r <= in_write_data;
    end
  end

  // Transaction decode.
  always_comb begin
    widx_ext  = {3'b000, req_widx_r};
    is_unm    = req_sel_r[2];
    is_pb     = (req_sel_r == SEL_PAGE);
    pb_in     = (widx_ext < 9'(PAGE_WORDS));
    is_scalar = !req_sel_r[2] && !is_pb && (req_widx_r == 6'd0);
    wide      = mode_r[0];
    var_ok    = (!req_data_r[0]) == wide;
    span_ok   = (addr_r < 32'(FLASH_BYTES));
    cmd_go    = req_wr_r && is_scalar && (req_sel_r == SEL_CMD);

    case (req_data_r)
      CMD_FLAG_STATUS:            op = OP_FLAG;
      CMD_ERASE_3B, CMD_ERASE_4B: op = var_ok ? OP_ERASE : OP_BAD;
      CMD_PROG_3B, CMD_PROG_4B:   op = var_ok ? OP_PROG : OP_BAD;
      CMD_READ_3B, CMD_READ_4B:   op = var_ok ? OP_READ : OP_BAD;
      CMD_WREN:                   op = OP_WREN;
      CMD_WRDI:                   op = OP_WRDI;
      default:                    op = OP_BAD;
    endcase

    run = RUN_NONE;
    if (cmd_go) begin
      if (op == OP_ERASE && wen_r && span_ok) begin
        run = RUN_ERASE;
      end else if (op == OP_PROG && wen_r && span_ok) begin
        run = RUN_PROG;
      end else if (op == OP_READ && span_ok) begin
        run = RUN_READ;
      end
    end else if (is_pb && pb_in && !req_wr_r) begin
      run = RUN_PBUF;
    end

    if (is_unm) begin
      dec_status = ST_UNMAPPED;
    end else if (cmd_go && op == OP_BAD) begin
      dec_status = ST_REJECT;
    end else begin
      dec_status = ST_OK;
    end

    dec_rdata = 32'd0;
    if (!req_wr_r && is_scalar) begin
      case (req_sel_r)
        SEL_MODE: dec_rdata = mode_r;
        SEL_ADDR: dec_rdata = addr_r;
        default:  dec_rdata = cmd_r;
      endcase
    end
  end

  // Register writes and command effects.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 32'd0;
      addr_r <= 32'd0;
      cmd_r  <= 32'd0;
      wen_r  <= 1'b0;
    end else if (cmd.decode && req_wr_r && is_scalar) begin
      case (req_sel_r)
        SEL_MODE: mode_r <= req_data_r;
        SEL_ADDR: addr_r <= wide ? req_data_r : (req_data_r & ADDR_MASK_NARROW);
        default: begin
          if (op != OP_BAD) begin
            cmd_r <= (op == OP_FLAG) ? CMD_FLAG_DONE : req_data_r;
          end
          if (op == OP_WREN) begin
            wen_r <= 1'b1;
          end else if (op == OP_WRDI) begin
            wen_r <= 1'b0;
          end
        end
      endcase
    end
  end

  // Byte sequencer for the clearing pass and the array operations.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      cnt_r <= '0;
    end else if (cmd.start) begin
      cur_r <= addr_r[AW-1:0];
      cnt_r <= '0;
    end else if (cmd.step) begin
      cur_r <= cur_r + AW'(1);
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // Flash array, one byte per cycle.
  always_comb begin
    fl_we = (cmd.fl_wsel != FW_NONE);
    case (cmd.fl_wsel)
      FW_ONES: fl_wd = 8'hFF;
      FW_AND:  fl_wd = fl_q_r & pb_byte;
      default: fl_wd = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      flash_mem[cur_r] <= fl_wd;
    end
    if (cmd.fl_rd) begin
      fl_q_r <= flash_mem[cur_r];
    end
  end

  // Page buffer port selection.
  always_comb begin
    bus_word  = widx_ext[PWW-1:0];
    op_word   = cnt_r[PWW+1:2];
    pb_ra     = cmd.pb_rd_bus ? bus_word : op_word;
    pb_rd     = cmd.pb_rd_bus || cmd.pb_rd_op;
    pb_bus_wr = cmd.decode && req_wr_r && is_pb && pb_in;
    pb_be     = 4'b0000;
    pb_wa     = op_word;
    pb_wd     = {4{fl_q_r}};
    if (pb_bus_wr) begin
      pb_be = 4'b1111;
      pb_wa = bus_word;
      pb_wd = req_data_r;
    end else if (cmd.pb_wr_op) begin
      pb_be = 4'b0001 << cnt_r[1:0];
    end
  end

  // Page buffer storage, word wide with byte enables.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (pb_be[l]) begin
        pb_mem[pb_wa][8*l +: 8] <= pb_wd[8*l +: 8];
      end
    end
    if (pb_rd) begin
      pb_q_r <= pb_mem[pb_ra];
    end
  end

  // Per-byte valid bits; a byte never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_vld_r <= '0;
      pb_vq_r  <= 4'b0000;
    end else begin
      for (int l = 0; l < 4; l++) begin
        if (pb_be[l]) begin
          pb_vld_r[{pb_wa, 2'(l)}] <= 1'b1;
        end
      end
      if (pb_rd) begin
        pb_vq_r <= pb_vld_r[{pb_ra, 2'b00} +: 4];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      pb_rdata[8*l +: 8] = pb_vq_r[l] ? pb_q_r[8*l +: 8] : 8'h00;
    end
    pb_byte = pb_rdata[8*cnt_r[1:0] +: 8];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_data_r   <= dec_rdata;
      res_status_r <= dec_status;
    end else if (cmd.take_pbuf) begin
      res_data_r <= pb_rdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r   <= res_data_r;
      out_status_r <= res_status_r;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.run        = run;
    stat.addr_end   = (cur_r == AW'(FLASH_BYTES - 1));
    stat.sector_end = (cnt_r == CW'(SECTOR_BYTES - 1));
    stat.page_end   = (cnt_r == CW'(PAGE_BYTES - 1));
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;

endmodule

@@ hdl/sfrm_ctrl.sv @@
module sfrm_ctrl
  import sfrm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DECODE = 10'b0000000100,
    S_PBWAIT = 10'b0000001000,
    S_ERASE  = 10'b0000010000,
    S_PRG_RD = 10'b0000100000,
    S_PRG_WR = 10'b0001000000,
    S_RD_RD  = 10'b0010000000,
    S_RD_WR  = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.fl_wsel = FW_ZERO;
        cmd.step    = 1'b1;
        if (stat.addr_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (stat.run)
          RUN_ERASE: begin
            cmd.start = 1'b1;
            state_nxt = S_ERASE;
          end
          RUN_PROG: begin
            cmd.start = 1'b1;
            state_nxt = S_PRG_RD;
          end
          RUN_READ: begin
            cmd.start = 1'b1;
            state_nxt = S_RD_RD;
          end
          RUN_PBUF: begin
            cmd.pb_rd_bus = 1'b1;
            state_nxt     = S_PBWAIT;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_PBWAIT: begin
        cmd.take_pbuf = 1'b1;
        state_nxt     = S_RESP;
      end
      S_ERASE: begin
        cmd.fl_wsel = FW_ONES;
        cmd.step    = 1'b1;
        if (stat.addr_end || stat.sector_end) begin
          state_nxt = S_RESP;
        end
      end
      S_PRG_RD: begin
        cmd.fl_rd    = 1'b1;
        cmd.pb_rd_op = 1'b1;
        state_nxt    = S_PRG_WR;
      end
      S_PRG_WR: begin
        cmd.fl_wsel = FW_AND;
        cmd.step    = 1'b1;
        state_nxt   = (stat.addr_end || stat.page_end) ? S_RESP : S_PRG_RD;
      end
      S_RD_RD: begin
        cmd.fl_rd = 1'b1;
        state_nxt = S_RD_WR;
      end
      S_RD_WR: begin
        cmd.pb_wr_op = 1'b1;
        cmd.step     = 1'b1;
        state_nxt    = (stat.addr_end || stat.page_end) ? S_RESP : S_RD_RD;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/spi_flash_register_model_unit.sv @@
// Register model of a SPI NOR flash behind a single-word register bus. Each
// transaction reads or writes the mode, address, command or page buffer
// register, or hits an unmapped select, and returns exactly one result word
// with a status. A register or page buffer access passes through accept,
// decode, a page buffer read when needed, and the result register.
// Commands written to the command register walk the byte-wide flash array
// byte by byte, and the bus waits until they end. A sector erase writes up
// to SECTOR_BYTES bytes; a page program or read does an array read, then a
// write, per byte for up to 4*PAGE_WORDS bytes; all stop at the array end.
// After reset the block sweeps the flash array to zero, one byte a cycle,
// over all FLASH_BYTES bytes before the first transaction is accepted. The
// result sits in an output register, so a new transaction is accepted while
// the previous result still waits to be taken.
module spi_flash_register_model_unit
  import sfrm_pkg::*;
#(
  parameter int FLASH_BYTES  = 1048576,
  parameter int PAGE_WORDS   = 64,
  parameter int SECTOR_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [2:0]  in_reg_select,
  input  logic [5:0]  in_word_index,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_status
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencing of transactions and array operations.
  sfrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Registers, memories and result path.
  sfrm_dp #(
    .FLASH_BYTES  (FLASH_BYTES),
    .PAGE_WORDS   (PAGE_WORDS),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .in_req_type   (in_req_type),
    .in_reg_select (in_reg_select),
    .in_word_index (in_word_index),
    .in_write_data (in_write_data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

endmodule
